FILE: src/csfr_pkg.sv
// csfr_pkg: shared types, constants and the byte-wide crc update
// for the crc16 status frame receiver; no dependencies
package csfr_pkg;

  localparam int unsigned PAYLOAD_BYTES = 24;
  localparam int unsigned CNT_W         = 8;

  localparam logic [7:0]       LEN_BYTE   = 8'(PAYLOAD_BYTES);
  localparam logic [CNT_W-1:0] LAST_IDX   = CNT_W'(PAYLOAD_BYTES - 1);
  localparam logic [CNT_W-1:0] CRC_HI_IDX = CNT_W'(PAYLOAD_BYTES - 2);

  localparam logic [7:0]  SYNC_BYTE   = 8'hfe;
  localparam logic [7:0]  CMD_RESET   = 8'h25;
  localparam logic [15:0] CRC_INIT    = 16'hffff;
  localparam logic [15:0] CRC_POLY    = 16'ha001;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_CMD = 2'd1,
    ST_BAD_CRC = 2'd2,
    ST_BAD_LEN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_SYNC1 = 2'd0,
    PH_SYNC2 = 2'd1,
    PH_LEN   = 2'd2,
    PH_DATA  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       frame_last;
    status_e    frame_status;
  } result_t;

  // reflected crc-16, one byte, unrolled
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  localparam logic [15:0] CRC_AFTER_SYNC = crc_byte(crc_byte(CRC_INIT, SYNC_BYTE), SYNC_BYTE);

endpackage

FILE: src/csfr_intf.sv
// csfr channel interfaces: received byte, result and config write
// depends on csfr_pkg
interface csfr_rx_if import csfr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface csfr_res_if import csfr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       frame_last;
  status_e    frame_status;

  modport source (output valid, output data_byte, output data_valid,
                  output frame_last, output frame_status, input ready);
  modport sink (input valid, input data_byte, input data_valid,
                input frame_last, input frame_status, output ready);
endinterface

interface csfr_cfg_if import csfr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] expected_command;

  modport source (output valid, output expected_command, input ready);
  modport sink (input valid, input expected_command, output ready);
endinterface

FILE: src/csfr_frame_fsm.sv
// csfr_frame_fsm: sync hunt, length check, payload pass-through, command and crc check
// depends on csfr_pkg
module csfr_frame_fsm import csfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] expected_command_i,
  output result_t    res_o,
  output logic       res_valid_o
);

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       crc_hi_q, crc_hi_d;
  logic             cmd_ok_q, cmd_ok_d;
  logic             cmd_ok_now;
  logic             at_last;

  assign cmd_ok_now = (count_q == '0) ? (byte_i == expected_command_i) : cmd_ok_q;
  assign at_last    = (count_q >= LAST_IDX);

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    crc_d    = crc_q;
    crc_hi_d = crc_hi_q;
    cmd_ok_d = cmd_ok_q;
    case (phase_q)
      PH_SYNC1: begin
        if (byte_i == SYNC_BYTE) phase_d = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (byte_i == SYNC_BYTE) begin
          crc_d   = CRC_AFTER_SYNC;
          phase_d = PH_LEN;
        end else begin
          phase_d = PH_SYNC1;
        end
      end
      PH_LEN: begin
        if (byte_i == LEN_BYTE) begin
          crc_d    = crc_byte(crc_q, byte_i);
          count_d  = '0;
          cmd_ok_d = 1'b0;
          phase_d  = PH_DATA;
        end else begin
          phase_d = PH_SYNC1;
        end
      end
      PH_DATA: begin
        cmd_ok_d = cmd_ok_now;
        if (at_last) begin
          phase_d = PH_SYNC1;
          count_d = '0;
        end else begin
          if (count_q == CRC_HI_IDX) crc_hi_d = byte_i;
          else crc_d = crc_byte(crc_q, byte_i);
          count_d = count_q + CNT_W'(1);
        end
      end
      default: phase_d = PH_SYNC1;
    endcase
  end

  always_comb begin
    res_valid_o        = 1'b0;
    res_o.data_byte    = byte_i;
    res_o.data_valid   = 1'b1;
    res_o.frame_last   = 1'b0;
    res_o.frame_status = ST_OK;
    case (phase_q)
      PH_LEN: begin
        if (byte_i != LEN_BYTE) begin
          res_valid_o        = 1'b1;
          res_o.data_byte    = 8'h00;
          res_o.data_valid   = 1'b0;
          res_o.frame_last   = 1'b1;
          res_o.frame_status = ST_BAD_LEN;
        end
      end
      PH_DATA: begin
        res_valid_o = 1'b1;
        if (at_last) begin
          res_o.frame_last = 1'b1;
          if (!cmd_ok_now) res_o.frame_status = ST_BAD_CMD;
          else if ({crc_hi_q, byte_i} != crc_q) res_o.frame_status = ST_BAD_CRC;
          else res_o.frame_status = ST_OK;
        end
      end
      default: res_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SYNC1;
      count_q  <= '0;
      crc_q    <= CRC_INIT;
      crc_hi_q <= 8'h00;
      cmd_ok_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      crc_q    <= crc_d;
      crc_hi_q <= crc_hi_d;
      cmd_ok_q <= cmd_ok_d;
    end
  end

endmodule

FILE: src/crc16_status_frame_receiver_top.sv
// crc16_status_frame_receiver_top: input register, frame fsm, result register
// depends on csfr_pkg, csfr_intf, csfr_frame_fsm
//
// channel  dir  payload                                           transfer
// rx_i     in   rx_byte[7:0]                                      valid & ready
// res_o    out  data_byte[7:0] data_valid frame_last frame_status valid & ready
// cfg_i    in   expected_command[7:0]                             valid & ready
//
// one byte per cycle sustained while no held result stalls rx; a byte that
// gives a result passes the input register, then the result register.
// reset clears fsm state, the crc to 0xffff and expected_command to 0x25.
// a held result stalls rx only when the next byte would also give a result.
// cfg_i is always ready.
module crc16_status_frame_receiver_top import csfr_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  csfr_rx_if.sink     rx_i,
  csfr_res_if.source  res_o,
  csfr_cfg_if.sink    cfg_i
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic [7:0] cmd_q;
  logic       out_valid_q;
  result_t    out_q;
  result_t    res;
  logic       res_valid;
  logic       out_free;
  logic       advance;

  assign out_free = !out_valid_q || res_o.ready;
  assign advance  = in_valid_q && (!res_valid || out_free);

  assign rx_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  csfr_frame_fsm u_fsm (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (advance),
    .byte_i             (in_byte_q),
    .expected_command_i (cmd_q),
    .res_o              (res),
    .res_valid_o        (res_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= CMD_RESET;
    end else if (cfg_i.valid) begin
      cmd_q <= cfg_i.expected_command;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) in_byte_q <= rx_i.rx_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) out_q <= res;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.data_byte    = out_q.data_byte;
  assign res_o.data_valid   = out_q.data_valid;
  assign res_o.frame_last   = out_q.frame_last;
  assign res_o.frame_status = out_q.frame_status;

endmodule

FILE: src/csfr_checker.sv
// csfr_checker: port-level assertions on the result channel, bound to the top
// depends on csfr_pkg, crc16_status_frame_receiver_top
module csfr_checker import csfr_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] data_byte_i,
  input logic       data_valid_i,
  input logic       frame_last_i,
  input status_e    frame_status_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(data_byte_i) &&
      $stable(data_valid_i) && $stable(frame_last_i) && $stable(frame_status_i))
    else $error("result changed while stalled");

  a_status_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !frame_last_i |-> frame_status_i == ST_OK)
    else $error("status set on a non-final result");

  a_bad_len_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && frame_status_i == ST_BAD_LEN |-> !data_valid_i &&
      data_byte_i == 8'h00 && frame_last_i)
    else $error("bad length result carries data");

  a_no_data_is_bad_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !data_valid_i |-> frame_status_i == ST_BAD_LEN)
    else $error("result without data is not a bad length");

endmodule

bind crc16_status_frame_receiver_top csfr_checker u_csfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .data_byte_i    (res_o.data_byte),
  .data_valid_i   (res_o.data_valid),
  .frame_last_i   (res_o.frame_last),
  .frame_status_i (res_o.frame_status)
);
